// ----- hdl/assert_macros.svh -----
// Assertion helpers shared by the checkers of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, idle while reset is high.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication violated");

// Next-cycle implication, idle while reset is high.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication violated");

`endif

// ----- hdl/arpc_pkg.sv -----
`default_nettype none
package arpc_pkg;

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_OWN_IP = 2'd0;

   localparam logic ACTION_PACKET = 1'b0;
   localparam logic ACTION_LOOKUP = 1'b1;

   localparam logic [15:0] HW_TYPE_ETHERNET = 16'h0001;
   localparam logic [15:0] PROTO_TYPE_IPV4  = 16'h0800;
   localparam logic [7:0]  HW_LEN_ETHERNET  = 8'd6;
   localparam logic [7:0]  PROTO_LEN_IPV4   = 8'd4;
   localparam logic [15:0] ARP_OP_REQUEST   = 16'd1;
   localparam logic [15:0] ARP_OP_REPLY     = 16'd2;

   localparam logic [2:0] STATUS_IGNORED     = 3'd0;
   localparam logic [2:0] STATUS_REPLY       = 3'd1;
   localparam logic [2:0] STATUS_LEARNED     = 3'd2;
   localparam logic [2:0] STATUS_LOOKUP_HIT  = 3'd3;
   localparam logic [2:0] STATUS_LOOKUP_MISS = 3'd4;

   localparam logic [1:0] OUT_OP_NONE    = 2'd0;
   localparam logic [1:0] OUT_OP_REQUEST = 2'd1;
   localparam logic [1:0] OUT_OP_REPLY   = 2'd2;

   localparam logic [47:0] BROADCAST_MAC = {6{8'hff}};

   typedef struct packed {
      logic [31:0] ip;
      logic [47:0] mac;
   } entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      KIND_IGNORE,
      KIND_REPLY,
      KIND_LEARN,
      KIND_LOOKUP
   } kind_type;

endpackage
`default_nettype wire

// ----- hdl/arp_responder_and_cache_core.sv -----
`default_nettype none
// ARP responder with an IPv4-to-MAC cache. Each transfer on the req_ channel is a parsed
// ARP packet or a lookup query and yields exactly one transfer on the rsp_ channel. The
// cache entries sit in a synchronous memory with one read port, scanned one entry per
// cycle, so a lookup or a learned reply scans the table until a hit or its last entry; a
// reply to a request, a malformed packet or an ignored opcode goes without a scan. One
// item is worked at a time; the finished result waits in the rsp_ output register while
// the next item is taken. Valid bits are flip-flops cleared by reset, so no clearing
// pass runs. own_ip is written through csr_ index 0; own_mac, index 1, only sources
// frames downstream and is not stored here. csr_ is always ready.
module arp_responder_and_cache_core #(
   parameter int TABLE_ENTRIES = 16
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_valid,
   output logic                              req_ready,
   input  wire                               req_action,
   input  wire  [15:0]                       req_hw_type,
   input  wire  [15:0]                       req_proto_type,
   input  wire  [7:0]                        req_hw_len,
   input  wire  [7:0]                        req_proto_len,
   input  wire  [15:0]                       req_opcode,
   input  wire  [47:0]                       req_sender_mac,
   input  wire  [31:0]                       req_src_ip,
   input  wire  [31:0]                       req_tgt_ip,
   input  wire  [31:0]                       req_query_ip,
   output logic                              rsp_valid,
   input  wire                               rsp_ready,
   output logic [2:0]                        rsp_status,
   output logic [1:0]                        rsp_out_opcode,
   output logic [47:0]                       rsp_out_dst_mac,
   output logic [47:0]                       rsp_out_target_mac,
   output logic [31:0]                       rsp_out_tgt_ip,
   output logic [47:0]                       rsp_found_mac,
   input  wire                               csr_valid,
   output logic                              csr_ready,
   input  wire  [arpc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire  [47:0]                       csr_wdata
);
   import arpc_pkg::*;

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

   state_type state_ff, state_in;
   kind_type  kind_ff, kind_in, kind_dec;

   logic [47:0] sender_mac_ff, sender_mac_in;
   logic [31:0] src_ip_ff, src_ip_in;
   logic [31:0] key_ip_ff, key_ip_in;
   logic [31:0] own_ip_ff, own_ip_in;

   logic [TABLE_ENTRIES-1:0] valid_ff, valid_in;
   logic [IDX_W-1:0] ptr_ff, ptr_in;
   logic [IDX_W-1:0] cnt_ff, cnt_in;
   logic             issue_done_ff, issue_done_in;
   logic             rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;
   entry_type        rd_data_ff;
   logic             hit_ff, hit_in;
   logic [IDX_W-1:0] hit_idx_ff, hit_idx_in;
   logic [47:0]      hit_mac_ff, hit_mac_in;
   logic             free_found_ff, free_found_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  rsp_status_ff, rsp_status_in;
   logic [1:0]  rsp_opcode_ff, rsp_opcode_in;
   logic [47:0] rsp_dst_mac_ff, rsp_dst_mac_in;
   logic [47:0] rsp_tgt_mac_ff, rsp_tgt_mac_in;
   logic [31:0] rsp_tgt_ip_ff, rsp_tgt_ip_in;
   logic [47:0] rsp_found_ff, rsp_found_in;

   entry_type        mem [TABLE_ENTRIES];
   logic             mem_we;
   logic [IDX_W-1:0] wr_idx;
   entry_type        wr_data;

   logic well_formed, scan_cmp, match, out_free, finish_go;

   assign req_ready   = (state_ff == ST_IDLE);
   assign csr_ready   = 1'b1;
   assign well_formed = (req_hw_type == HW_TYPE_ETHERNET) && (req_proto_type == PROTO_TYPE_IPV4)
                        && (req_hw_len == HW_LEN_ETHERNET) && (req_proto_len == PROTO_LEN_IPV4);
   assign scan_cmp    = (state_ff == ST_SCAN) && rd_vld_ff;
   assign match       = scan_cmp && valid_ff[rd_idx_ff] && (rd_data_ff.ip == key_ip_ff);
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign finish_go   = (state_ff == ST_FINISH) && out_free;

   always_comb begin
      priority if (req_action == ACTION_LOOKUP) begin
         kind_dec = KIND_LOOKUP;
      end else if (!well_formed) begin
         kind_dec = KIND_IGNORE;
      end else if (req_opcode == ARP_OP_REQUEST && req_tgt_ip == own_ip_ff) begin
         kind_dec = KIND_REPLY;
      end else if (req_opcode == ARP_OP_REPLY) begin
         kind_dec = KIND_LEARN;
      end else begin
         kind_dec = KIND_IGNORE;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (kind_dec == KIND_LEARN || kind_dec == KIND_LOOKUP) ? ST_SCAN
                                                                              : ST_FINISH;
            end
         end
         ST_SCAN: begin
            if (match || (scan_cmp && rd_idx_ff == LAST_IDX)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      kind_in        = kind_ff;
      sender_mac_in  = sender_mac_ff;
      src_ip_in      = src_ip_ff;
      key_ip_in      = key_ip_ff;
      own_ip_in      = own_ip_ff;
      valid_in       = valid_ff;
      ptr_in         = ptr_ff;
      cnt_in         = cnt_ff;
      issue_done_in  = issue_done_ff;
      rd_vld_in      = (state_ff == ST_SCAN) && !issue_done_ff;
      rd_idx_in      = cnt_ff;
      hit_in         = hit_ff;
      hit_idx_in     = hit_idx_ff;
      hit_mac_in     = hit_mac_ff;
      free_found_in  = free_found_ff;
      free_idx_in    = free_idx_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_opcode_in  = rsp_opcode_ff;
      rsp_dst_mac_in = rsp_dst_mac_ff;
      rsp_tgt_mac_in = rsp_tgt_mac_ff;
      rsp_tgt_ip_in  = rsp_tgt_ip_ff;
      rsp_found_in   = rsp_found_ff;
      mem_we         = 1'b0;
      wr_data        = '{ip: key_ip_ff, mac: sender_mac_ff};
      priority if (hit_ff) begin
         wr_idx = hit_idx_ff;
      end else if (free_found_ff) begin
         wr_idx = free_idx_ff;
      end else begin
         wr_idx = ptr_ff;
      end

      if (csr_valid && csr_index == CSR_OWN_IP) begin
         own_ip_in = csr_wdata[31:0];
      end

      // latch the item and arm the scan
      if (state_ff == ST_IDLE && req_valid) begin
         kind_in       = kind_dec;
         sender_mac_in = req_sender_mac;
         src_ip_in     = req_src_ip;
         key_ip_in     = (req_action == ACTION_LOOKUP) ? req_query_ip : req_src_ip;
         cnt_in        = '0;
         issue_done_in = 1'b0;
         hit_in        = 1'b0;
         free_found_in = 1'b0;
      end

      if (state_ff == ST_SCAN && !issue_done_ff) begin
         if (cnt_ff == LAST_IDX) begin
            issue_done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff + 1'b1;
         end
      end

      if (match) begin
         hit_in     = 1'b1;
         hit_idx_in = rd_idx_ff;
         hit_mac_in = rd_data_ff.mac;
      end

      if (scan_cmp && !valid_ff[rd_idx_ff] && !free_found_ff) begin
         free_found_in = 1'b1;
         free_idx_in   = rd_idx_ff;
      end

      if (finish_go) begin
         rsp_valid_in   = 1'b1;
         rsp_status_in  = STATUS_IGNORED;
         rsp_opcode_in  = OUT_OP_NONE;
         rsp_dst_mac_in = '0;
         rsp_tgt_mac_in = '0;
         rsp_tgt_ip_in  = '0;
         rsp_found_in   = '0;
         unique case (kind_ff)
            KIND_IGNORE: begin
               rsp_status_in = STATUS_IGNORED;
            end
            KIND_REPLY: begin
               rsp_status_in  = STATUS_REPLY;
               rsp_opcode_in  = OUT_OP_REPLY;
               rsp_dst_mac_in = sender_mac_ff;
               rsp_tgt_mac_in = sender_mac_ff;
               rsp_tgt_ip_in  = src_ip_ff;
            end
            KIND_LEARN: begin
               rsp_status_in    = STATUS_LEARNED;
               mem_we           = 1'b1;
               valid_in[wr_idx] = 1'b1;
               if (!hit_ff && !free_found_ff) begin
                  ptr_in = (ptr_ff == LAST_IDX) ? '0 : ptr_ff + 1'b1;
               end
            end
            KIND_LOOKUP: begin
               if (hit_ff) begin
                  rsp_status_in = STATUS_LOOKUP_HIT;
                  rsp_found_in  = hit_mac_ff;
               end else begin
                  rsp_status_in  = STATUS_LOOKUP_MISS;
                  rsp_opcode_in  = OUT_OP_REQUEST;
                  rsp_dst_mac_in = BROADCAST_MAC;
                  rsp_tgt_ip_in  = key_ip_ff;
               end
            end
            default: rsp_status_in = STATUS_IGNORED;
         endcase
      end else if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_idx] <= wr_data;
      end
      rd_data_ff <= mem[cnt_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         own_ip_ff     <= '0;
         valid_ff      <= '0;
         ptr_ff        <= '0;
         issue_done_ff <= 1'b0;
         rd_vld_ff     <= 1'b0;
         hit_ff        <= 1'b0;
         free_found_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         own_ip_ff     <= own_ip_in;
         valid_ff      <= valid_in;
         ptr_ff        <= ptr_in;
         issue_done_ff <= issue_done_in;
         rd_vld_ff     <= rd_vld_in;
         hit_ff        <= hit_in;
         free_found_ff <= free_found_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff        <= kind_in;
      sender_mac_ff  <= sender_mac_in;
      src_ip_ff      <= src_ip_in;
      key_ip_ff      <= key_ip_in;
      cnt_ff         <= cnt_in;
      rd_idx_ff      <= rd_idx_in;
      hit_idx_ff     <= hit_idx_in;
      hit_mac_ff     <= hit_mac_in;
      free_idx_ff    <= free_idx_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_opcode_ff  <= rsp_opcode_in;
      rsp_dst_mac_ff <= rsp_dst_mac_in;
      rsp_tgt_mac_ff <= rsp_tgt_mac_in;
      rsp_tgt_ip_ff  <= rsp_tgt_ip_in;
      rsp_found_ff   <= rsp_found_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_out_opcode     = rsp_opcode_ff;
   assign rsp_out_dst_mac    = rsp_dst_mac_ff;
   assign rsp_out_target_mac = rsp_tgt_mac_ff;
   assign rsp_out_tgt_ip     = rsp_tgt_ip_ff;
   assign rsp_found_mac      = rsp_found_ff;

endmodule
`default_nettype wire

// ----- hdl/arpc_checker.sv -----
`default_nettype none
`include "assert_macros.svh"
module arpc_checker (
   input wire                            clock,
   input wire                            reset,
   input wire                            req_valid,
   input wire                            req_ready,
   input wire                            rsp_valid,
   input wire                            rsp_ready,
   input wire [2:0]                      rsp_status,
   input wire [1:0]                      rsp_out_opcode,
   input wire [47:0]                     rsp_out_dst_mac,
   input wire [47:0]                     rsp_out_target_mac,
   input wire [47:0]                     rsp_found_mac
);
   import arpc_pkg::*;

   logic req_xfer, quiet_status;

   assign req_xfer     = req_valid && req_ready;
   assign quiet_status = (rsp_status == STATUS_IGNORED) || (rsp_status == STATUS_LEARNED);

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_status) && $stable(rsp_found_mac))
   `ASSERT_NEXT(a_one_item, clock, reset, req_xfer, !req_ready)
   `ASSERT_IMPLY(a_quiet_zero, clock, reset, rsp_valid && quiet_status,
      rsp_out_opcode == OUT_OP_NONE && rsp_out_dst_mac == '0 && rsp_found_mac == '0)
   `ASSERT_IMPLY(a_miss_bcast, clock, reset, rsp_valid && rsp_status == STATUS_LOOKUP_MISS,
      rsp_out_opcode == OUT_OP_REQUEST && rsp_out_dst_mac == BROADCAST_MAC
      && rsp_out_target_mac == '0)
   `ASSERT_IMPLY(a_reply_dst, clock, reset, rsp_valid && rsp_status == STATUS_REPLY,
      rsp_out_opcode == OUT_OP_REPLY && rsp_out_dst_mac == rsp_out_target_mac)

endmodule

bind arp_responder_and_cache_core arpc_checker u_arpc_checker (.*);
`default_nettype wire
